// ----- design/sspc_pkg.sv -----
// Package for the straight-drive speed and phase PI controller.
// Holds field widths, controller constants, codes and the lane result struct.
package sspc_pkg;

  localparam int unsigned CntW    = 32;
  localparam int unsigned DutyW   = 14;
  localparam int unsigned SensW   = 14;
  localparam int unsigned RpmW    = 16;
  localparam int unsigned StepsW  = 31;
  localparam int unsigned DelayW  = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 31;

  localparam int unsigned NumLanes = 2;

  localparam logic [24:0] RpmScale   = 25'd20000000;
  localparam int          DutyMax    = 14999;
  localparam int          DutyMin    = 1200;
  localparam int          StartFloor = 1400;
  localparam int          StartCeil  = 2200;
  localparam int          StartSpan  = 800;
  localparam int          RefDist    = 654;
  localparam int          DelayMax   = 80;
  localparam int          DelayMin   = 15;
  localparam int          IntLimit   = 1800;
  localparam int          PhaseLimit = 800;
  localparam logic [13:0] WallReset  = 14'd8900;

  // Reciprocal of 654: exact floor for products below 2^29 / 304
  localparam logic [19:0] RefDistRecip = 20'd820904;
  localparam int unsigned RefDistShift = 29;
  // Reciprocal of 10: exact floor for magnitudes up to 1800
  localparam logic [10:0] TenthRecip   = 11'd1639;
  localparam int unsigned TenthShift   = 14;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegLeftRpm    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRightRpm   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLeftSteps  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRightSteps = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWall       = 3'd4;

  typedef enum logic [1:0] {
    CmdKeep    = 2'd0,
    CmdForward = 2'd1,
    CmdStop    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StRunning  = 3'd0,
    StDistance = 3'd1,
    StObstacle = 3'd2,
    StRejected = 3'd3,
    StSkipped  = 3'd4,
    StIdle     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle = 2'd0,
    FsmRpm  = 2'd1,
    FsmPi   = 2'd2,
    FsmOut  = 2'd3
  } fsm_e;

  // Lane control: start, and what the lane reports back
  typedef struct packed {
    logic start;
  } lane_ctl_t;

  typedef struct packed {
    logic            done;
    logic [RpmW-1:0] rpm;
  } lane_res_t;

endpackage

// ----- design/sspc_if.sv -----
// Valid/ready stream interface carrying one payload.
// Depends on nothing but the payload type handed in.
interface sspc_if #(
  parameter type payload_t = logic
) (
  input logic clk_i
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/sspc_rpm_lane.sv -----
// One wheel lane: delta*20000000/dt by a restoring divider, one bit a cycle.
// Uses sspc_pkg for widths and the lane structs.
module sspc_rpm_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sspc_pkg::lane_ctl_t       ctl_i,
  input  logic [sspc_pkg::CntW-1:0] delta_i,
  input  logic [sspc_pkg::CntW-1:0] dt_i,
  output sspc_pkg::lane_res_t       res_o
);
  import sspc_pkg::*;

  localparam int unsigned NumW = 57;
  localparam int unsigned BitW = 6;

  logic [NumW-1:0] num_q, num_d;
  logic [CntW:0]   rem_q, rem_d;
  logic [CntW-1:0] dt_q;
  logic [BitW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            zero_q, zero_d;
  logic [CntW:0]   trial;
  logic [NumW-1:0] product;

  assign product = NumW'(delta_i) * NumW'(RpmScale);
  assign trial   = {rem_q[CntW-1:0], num_q[NumW-1]};

  // Shift one quotient bit per cycle into num
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    zero_d = zero_q;
    if (ctl_i.start) begin
      num_d  = product;
      rem_d  = '0;
      cnt_d  = BitW'(NumW);
      busy_d = 1'b1;
      zero_d = (delta_i == '0) || (dt_i == '0);
    end else if (busy_q) begin
      if (trial >= {1'b0, dt_q}) begin
        rem_d = trial - {1'b0, dt_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == BitW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    zero_q <= zero_d;
    if (ctl_i.start) dt_q <= dt_i;
  end

  assign res_o.done = busy_q && (cnt_q == BitW'(1));
  assign res_o.rpm  = zero_q ? '0 : num_d[RpmW-1:0];
endmodule

// ----- design/sspc_merge.sv -----
// Merge stage: speed PI and phase PI over the two lane results.
// Uses sspc_pkg constants; registered state is kept by the top level.
module sspc_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [sspc_pkg::RpmW-1:0] rpm_l_i,
  input  logic [sspc_pkg::RpmW-1:0] rpm_r_i,
  input  logic [16:0]              tgt_sum_i,
  input  logic [31:0]              ml_i,
  input  logic [31:0]              mr_i,
  input  logic signed [11:0]       si_i,
  input  logic signed [11:0]       pi_i,
  input  logic [sspc_pkg::DutyW-1:0] base_i,
  output logic signed [11:0]       si_o,
  output logic signed [11:0]       pi_o,
  output logic [sspc_pkg::DutyW-1:0] base_o,
  output logic [sspc_pkg::DutyW-1:0] ld_o,
  output logic [sspc_pkg::DutyW-1:0] rd_o
);
  import sspc_pkg::*;

  logic signed [17:0] err;
  logic signed [33:0] pe;
  logic signed [18:0] si_sum;
  logic signed [34:0] pi_sum;
  logic signed [11:0] si_n, pi_n;
  logic signed [19:0] bd_raw;
  logic [DutyW-1:0]   bd;
  logic signed [11:0] pe_q;
  logic signed [36:0] pe4_q;
  logic signed [11:0] pi_q;
  logic [DutyW-1:0]   bd_q;
  logic [10:0]        pi_abs;
  logic [21:0]        pi_div_m;
  logic signed [11:0] pi_div;
  logic signed [37:0] corr_raw;
  logic signed [10:0] corr;
  logic signed [15:0] ld_raw, rd_raw;
  logic               stage_q;

  // Speed PI and phase integral, first stage
  always_comb begin
    err    = $signed({2'b0, tgt_sum_i[16:1]}) - $signed({1'b0, ({1'b0, rpm_l_i} +
             {1'b0, rpm_r_i}) >> 1});
    si_sum = 19'(si_i) + 19'(err);
    if (si_sum > 19'(IntLimit)) si_n = 12'(IntLimit);
    else if (si_sum < -19'(IntLimit)) si_n = -12'(IntLimit);
    else si_n = si_sum[11:0];
    bd_raw = 20'($signed({1'b0, base_i})) + 20'(err) * 20'sd2 + 20'(si_n / 12'sd16);
    if (bd_raw > 20'(DutyMax)) bd = DutyW'(DutyMax);
    else if (bd_raw < 20'(DutyMin)) bd = DutyW'(DutyMin);
    else bd = bd_raw[DutyW-1:0];
    pe     = $signed({2'b0, ml_i}) - $signed({2'b0, mr_i});
    pi_sum = 35'(pi_i) + 35'(pe);
    if (pi_sum > 35'(IntLimit)) pi_n = 12'(IntLimit);
    else if (pi_sum < -35'(IntLimit)) pi_n = -12'(IntLimit);
    else pi_n = pi_sum[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stage_q <= 1'b0;
    else stage_q <= load_i;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pe4_q <= 37'(pe) * 37'sd4;
      pi_q  <= pi_n;
      bd_q  <= bd;
      pe_q  <= si_n;
    end
  end

  // Phase correction and duty split, second stage
  always_comb begin
    // Divide the phase integral by 10 toward zero: magnitude times reciprocal
    pi_abs   = pi_q[11] ? 11'(-pi_q) : pi_q[10:0];
    pi_div_m = 22'(pi_abs) * 22'(TenthRecip);
    pi_div   = pi_q[11] ? -12'(pi_div_m[21:TenthShift]) : 12'(pi_div_m[21:TenthShift]);
    corr_raw = 38'(pe4_q) + 38'(pi_div);
    if (corr_raw > 38'(PhaseLimit)) corr = 11'(PhaseLimit);
    else if (corr_raw < -38'(PhaseLimit)) corr = -11'(PhaseLimit);
    else corr = corr_raw[10:0];
    ld_raw = $signed({2'b0, bd_q}) - 16'(corr);
    rd_raw = $signed({2'b0, bd_q}) + 16'(corr);
    if (ld_raw > 16'(DutyMax)) ld_o = DutyW'(DutyMax);
    else if (ld_raw < 16'(DutyMin)) ld_o = DutyW'(DutyMin);
    else ld_o = ld_raw[DutyW-1:0];
    if (rd_raw > 16'(DutyMax)) rd_o = DutyW'(DutyMax);
    else if (rd_raw < 16'(DutyMin)) rd_o = DutyW'(DutyMin);
    else rd_o = rd_raw[DutyW-1:0];
  end

  assign si_o   = pe_q;
  assign pi_o   = pi_q;
  assign base_o = bd_q;

`ifndef SYNTH
  // The second stage only follows a load
  a_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q |-> $past(load_i)) else $error("merge stage without load");
  // Registered integrals stay within their limits
  a_si: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q |-> (si_o <= 12'sd1800 && si_o >= -12'sd1800)) else $error("speed int");
  a_pi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q |-> (pi_o <= 12'sd1800 && pi_o >= -12'sd1800)) else $error("phase int");
`endif
endmodule

// ----- design/straight_speed_phase_pi_control.sv -----
// Straight-drive controller: each transfer is a start request or a sample and
// returns one result. A start or an idle/wall/distance sample answers in the cycle
// after its transfer; a running sample goes through 57 steps of the two wheel
// lanes, each a restoring divider for delta*20000000/dt, then two PI merge stages
// (only the first merge stage when a wheel speed is zero and the sample is skipped).
// One item is in work at a time; the input is ready while no sample is in work and
// the output register is empty or being taken. Uses sspc_pkg and sspc_if.
module straight_speed_phase_pi_control (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sspc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sspc_pkg::CfgW-1:0]         cfg_data_i,
  sspc_if.sink                              in_ch,
  sspc_if.source                            out_ch
);
  import sspc_pkg::*;

  // Config registers
  logic [RpmW-1:0]   lrpm_q, rrpm_q;
  logic [StepsW-1:0] lsteps_q, rsteps_q;
  logic [SensW-1:0]  wall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrpm_q <= '0; rrpm_q <= '0; lsteps_q <= '0; rsteps_q <= '0; wall_q <= WallReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLeftRpm:    lrpm_q   <= cfg_data_i[RpmW-1:0];
        RegRightRpm:   rrpm_q   <= cfg_data_i[RpmW-1:0];
        RegLeftSteps:  lsteps_q <= cfg_data_i;
        RegRightSteps: rsteps_q <= cfg_data_i;
        RegWall:       wall_q   <= cfg_data_i[SensW-1:0];
        default: ;
      endcase
    end
  end

  // Controller state
  logic [CntW-1:0] sl_q, sr_q, pl_q, pr_q, plt_q, prt_q;
  logic [DutyW-1:0] base_q;
  logic signed [11:0] si_q, pi_q;
  logic [1:0] poll_q;
  logic active_q;
  logic [CntW-1:0] ml_q, mr_q;

  fsm_e st_q, st_d;
  logic out_v_q;
  logic [DutyW-1:0] ol_q, or_q;
  logic [1:0] ocmd_q;
  logic [2:0] ost_q;
  logic [DelayW-1:0] odly_q;

  logic acc;
  assign in_ch.ready = (st_q == FsmIdle) && (!out_v_q || out_ch.ready);
  assign acc = in_ch.valid && in_ch.ready;

  // Decode of the incoming item
  logic [CntW-1:0] lc, rc, dl, dr, mld, mrd, dpl, dpr;
  logic [31:0] a_sum;
  logic [30:0] avg_goal;
  logic [32:0] moved_sum;
  logic reject, wall, poll3;
  logic [SensW-1:0] cmax;
  logic [DutyW-1:0] sduty;
  logic [DelayW-1:0] sdly;
  logic [19:0] span;
  logic [16:0] dspan;
  logic [39:0] span_m, dspan_m;

  function automatic logic [31:0] mag(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31] ? (32'd0 - d) : d;
  endfunction

  always_comb begin
    lc = in_ch.data.left_count;
    rc = in_ch.data.right_count;
    mld = mag(lc, sl_q);
    mrd = mag(rc, sr_q);
    dpl = mag(lc, pl_q);
    dpr = mag(rc, pr_q);
    dl = in_ch.data.left_stamp - plt_q;
    dr = in_ch.data.right_stamp - prt_q;
    a_sum = {1'b0, lsteps_q} + {1'b0, rsteps_q};
    avg_goal = a_sum[31:1];
    moved_sum = {1'b0, mld} + {1'b0, mrd};
    reject = (lsteps_q == '0) || (rsteps_q == '0) || (lrpm_q == '0) || (rrpm_q == '0);
    cmax = (in_ch.data.center_read_a > in_ch.data.center_read_b) ?
           in_ch.data.center_read_a : in_ch.data.center_read_b;
    poll3 = (poll_q == 2'd2);
    wall = poll3 && (cmax > wall_q);
    // Divide by 654 with a reciprocal multiply: a < 654 keeps products narrow
    span    = 20'(avg_goal[9:0]) * 20'(StartSpan);
    dspan   = 17'(avg_goal[9:0]) * 17'(DelayMax);
    span_m  = 40'(span) * 40'(RefDistRecip);
    dspan_m = 40'(dspan) * 40'(RefDistRecip);
    if (avg_goal >= 31'(RefDist)) begin
      sduty = DutyW'(StartCeil);
      sdly  = DelayW'(DelayMax);
    end else begin
      sduty = DutyW'(StartFloor) + DutyW'(span_m[39:RefDistShift]);
      sdly  = DelayW'(dspan_m[39:RefDistShift]);
      if (sdly < DelayW'(DelayMin)) sdly = DelayW'(DelayMin);
    end
  end

  // Lanes
  lane_ctl_t ctl;
  lane_res_t res_l, res_r;
  logic run_start;
  assign run_start = acc && in_ch.data.req_type && active_q && !wall &&
                     (moved_sum[32:1] < {1'b0, avg_goal});
  assign ctl.start = run_start;

  sspc_rpm_lane u_lane_l (.clk_i, .rst_ni, .ctl_i(ctl), .delta_i(dpl), .dt_i(dl),
                          .res_o(res_l));
  sspc_rpm_lane u_lane_r (.clk_i, .rst_ni, .ctl_i(ctl), .delta_i(dpr), .dt_i(dr),
                          .res_o(res_r));

  logic [RpmW-1:0] rl_q, rr_q;
  logic skip;
  assign skip = (rl_q == '0) || (rr_q == '0);
  logic load;
  assign load = (st_q == FsmPi) && !skip;

  logic signed [11:0] si_n, pi_n;
  logic [DutyW-1:0] base_n, ld, rd;
  sspc_merge u_merge (.clk_i, .rst_ni, .load_i(load), .rpm_l_i(rl_q), .rpm_r_i(rr_q),
    .tgt_sum_i({1'b0, lrpm_q} + {1'b0, rrpm_q}), .ml_i(ml_q), .mr_i(mr_q),
    .si_i(si_q), .pi_i(pi_q), .base_i(base_q), .si_o(si_n), .pi_o(pi_n),
    .base_o(base_n), .ld_o(ld), .rd_o(rd));

  // A new result is ready: immediate answer, skipped sample or PI output
  logic res_set;
  assign res_set = (acc && !run_start) || ((st_q == FsmPi) && skip) || (st_q == FsmOut);

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      FsmIdle: if (run_start) st_d = FsmRpm;
      FsmRpm:  if (res_l.done) st_d = FsmPi;
      FsmPi:   st_d = skip ? FsmIdle : FsmOut;
      FsmOut:  st_d = FsmIdle;
      default: st_d = FsmIdle;
    endcase
  end

  // Outputs: state updates and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FsmIdle; out_v_q <= 1'b0; active_q <= 1'b0; poll_q <= '0;
      sl_q <= '0; sr_q <= '0; pl_q <= '0; pr_q <= '0; plt_q <= '0; prt_q <= '0;
      base_q <= '0; si_q <= '0; pi_q <= '0;
    end else begin
      st_q <= st_d;
      // Set on a new result, clear once the result transfer happens
      if (res_set) out_v_q <= 1'b1;
      else if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
      if (acc) begin
        if (!in_ch.data.req_type) begin
          if (reject) begin
            active_q <= 1'b0;
            {ol_q, or_q, ocmd_q, ost_q, odly_q} <= {14'd0, 14'd0, CmdKeep, StRejected, 7'd0};
          end else begin
            base_q <= sduty; si_q <= '0; pi_q <= '0; poll_q <= '0;
            sl_q <= lc; pl_q <= lc; sr_q <= rc; pr_q <= rc;
            plt_q <= in_ch.data.left_stamp; prt_q <= in_ch.data.right_stamp;
            active_q <= 1'b1;
            {ol_q, or_q, ocmd_q, ost_q, odly_q} <= {sduty, sduty, CmdForward, StRunning, sdly};
          end
        end else if (!active_q) begin
          {ol_q, or_q, ocmd_q, ost_q, odly_q} <= {14'd0, 14'd0, CmdKeep, StIdle, 7'd0};
        end else begin
          poll_q <= poll3 ? 2'd0 : poll_q + 2'd1;
          if (wall) begin
            active_q <= 1'b0;
            {ol_q, or_q, ocmd_q, ost_q, odly_q} <= {14'd0, 14'd0, CmdStop, StObstacle, 7'd0};
          end else if (!run_start) begin
            active_q <= 1'b0;
            {ol_q, or_q, ocmd_q, ost_q, odly_q} <= {14'd0, 14'd0, CmdStop, StDistance, 7'd0};
          end else begin
            pl_q <= lc; pr_q <= rc;
            plt_q <= in_ch.data.left_stamp; prt_q <= in_ch.data.right_stamp;
            ml_q <= mld; mr_q <= mrd;
          end
        end
      end
      if (res_l.done) begin
        rl_q <= res_l.rpm; rr_q <= res_r.rpm;
      end
      if (st_q == FsmPi && skip) begin
        {ol_q, or_q, ocmd_q, ost_q, odly_q} <= {14'd0, 14'd0, CmdKeep, StSkipped, 7'd0};
      end
      if (st_q == FsmOut) begin
        si_q <= si_n; pi_q <= pi_n; base_q <= base_n;
        {ol_q, or_q, ocmd_q, ost_q, odly_q} <= {ld, rd, CmdForward, StRunning, 7'd0};
      end
    end
  end

  assign out_ch.valid = out_v_q;
  assign out_ch.data.left_drive = ol_q;
  assign out_ch.data.right_drive = or_q;
  assign out_ch.data.motor_command = ocmd_q;
  assign out_ch.data.status = ost_q;
  assign out_ch.data.start_delay_ms = odly_q;

`ifndef SYNTH
  // Both lanes run in lockstep
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_l.done == res_r.done) else $error("lanes out of step");
  // No input taken while a sample is in work
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != FsmIdle) |-> !in_ch.ready) else $error("ready while busy");
  // Drives are zero unless the command is forward
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && ocmd_q != CmdForward) |-> (ol_q == '0 && or_q == '0))
    else $error("nonzero drive");
`endif
endmodule

// ----- sim/straight_speed_phase_pi_control_test.sv -----
// Testbench for the straight-drive speed and phase PI controller.
// Random and directed moves, with a scoreboard predicting each result.
// Depends on sspc_pkg, sspc_if and straight_speed_phase_pi_control.
`timescale 1ns / 100ps

module straight_speed_phase_pi_control_test;
  import sspc_pkg::*;

  typedef struct packed {
    logic        req_type;
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic [31:0] left_stamp;
    logic [31:0] right_stamp;
    logic [13:0] center_read_a;
    logic [13:0] center_read_b;
  } drive_req_t;

  typedef struct packed {
    logic [13:0] left_drive;
    logic [13:0] right_drive;
    logic [1:0]  motor_command;
    logic [2:0]  status;
    logic [6:0]  start_delay_ms;
  } drive_res_t;

  localparam logic ReqStart  = 1'b0;
  localparam logic ReqSample = 1'b1;

  // Predicts the controller and checks its results in order
  class drive_scoreboard;
    bit [31:0] rpm_l, rpm_r, steps_l, steps_r, wall;
    bit [31:0] start_l, start_r, prev_l, prev_r, prev_lt, prev_rt;
    longint    base, speed_int, phase_int;
    int        poll;
    bit        running;
    drive_res_t pending[$];
    int        errors, checked;

    function void clear();
      rpm_l = 0; rpm_r = 0; steps_l = 0; steps_r = 0; wall = 8900;
      start_l = 0; start_r = 0; prev_l = 0; prev_r = 0; prev_lt = 0; prev_rt = 0;
      base = 0; speed_int = 0; phase_int = 0; poll = 0; running = 0;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, bit [31:0] val);
      case (idx)
        RegLeftRpm:    rpm_l = val & 32'hFFFF;
        RegRightRpm:   rpm_r = val & 32'hFFFF;
        RegLeftSteps:  steps_l = val & 32'h7FFF_FFFF;
        RegRightSteps: steps_r = val & 32'h7FFF_FFFF;
        RegWall:       wall = val & 32'h3FFF;
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function bit [31:0] magnitude(bit [31:0] a, bit [31:0] b);
      bit [31:0] d;
      d = a - b;
      return d[31] ? (32'd0 - d) : d;
    endfunction

    function bit [31:0] wheel_speed(bit [31:0] delta, bit [31:0] dt);
      longint unsigned q;
      if (delta == 0 || dt == 0) return 0;
      q = (longint'(delta) * 64'd20000000) / longint'(dt);
      return 32'(q & 64'hFFFF);
    endfunction

    function drive_res_t predict(drive_req_t r);
      drive_res_t o;
      longint a, ml, mr, err, pe, corr, bd;
      bit [31:0] rl, rr, ca, cb;
      o = '0;
      o.motor_command = CmdKeep;
      if (r.req_type == ReqStart) begin
        if (steps_l == 0 || steps_r == 0 || rpm_l == 0 || rpm_r == 0) begin
          running = 0;
          o.status = StRejected;
          return o;
        end
        a = (longint'(steps_l) + longint'(steps_r)) / 2;
        if (a >= RefDist) begin
          base = StartCeil;
          o.start_delay_ms = 7'(DelayMax);
        end else begin
          base = StartFloor + (StartSpan * a) / RefDist;
          o.start_delay_ms = 7'(((DelayMax * a) / RefDist < DelayMin) ? DelayMin
                                                                   : (DelayMax * a) / RefDist);
        end
        speed_int = 0; phase_int = 0; poll = 0;
        start_l = r.left_count; prev_l = r.left_count;
        start_r = r.right_count; prev_r = r.right_count;
        prev_lt = r.left_stamp; prev_rt = r.right_stamp;
        running = 1;
        o.left_drive = 14'(base); o.right_drive = 14'(base);
        o.motor_command = CmdForward;
        o.status = StRunning;
        return o;
      end
      if (!running) begin
        o.status = StIdle;
        return o;
      end
      // wall poll on every third sample
      poll++;
      if (poll >= 3) begin
        poll = 0;
        ca = 32'(r.center_read_a); cb = 32'(r.center_read_b);
        if ((ca > cb ? ca : cb) > wall) begin
          running = 0;
          o.motor_command = CmdStop; o.status = StObstacle;
          return o;
        end
      end
      ml = magnitude(r.left_count, start_l);
      mr = magnitude(r.right_count, start_r);
      if ((ml + mr) / 2 >= (longint'(steps_l) + longint'(steps_r)) / 2) begin
        running = 0;
        o.motor_command = CmdStop; o.status = StDistance;
        return o;
      end
      rl = wheel_speed(magnitude(r.left_count, prev_l), r.left_stamp - prev_lt);
      rr = wheel_speed(magnitude(r.right_count, prev_r), r.right_stamp - prev_rt);
      prev_l = r.left_count; prev_r = r.right_count;
      prev_lt = r.left_stamp; prev_rt = r.right_stamp;
      if (rl == 0 || rr == 0) begin
        o.status = StSkipped;
        return o;
      end
      // speed loop sets the common duty, phase loop splits it
      err = longint'((rpm_l + rpm_r) / 2) - longint'((rl + rr) / 2);
      speed_int = clip(speed_int + err, -IntLimit, IntLimit);
      bd = clip(base + 2 * err + speed_int / 16, DutyMin, DutyMax);
      base = bd;
      pe = ml - mr;
      phase_int = clip(phase_int + pe, -IntLimit, IntLimit);
      corr = clip(4 * pe + phase_int / 10, -PhaseLimit, PhaseLimit);
      o.left_drive = 14'(clip(bd - corr, DutyMin, DutyMax));
      o.right_drive = 14'(clip(bd + corr, DutyMin, DutyMax));
      o.motor_command = CmdForward;
      o.status = StRunning;
      return o;
    endfunction

    function void note_input(drive_req_t r);
      pending.push_back(predict(r));
    endfunction

    function void compare(string name, int e, int a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(drive_res_t a);
      drive_res_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, a);
        return;
      end
      e = pending.pop_front();
      compare("left_drive", e.left_drive, a.left_drive);
      compare("right_drive", e.right_drive, a.right_drive);
      compare("motor_command", e.motor_command, a.motor_command);
      compare("status", e.status, a.status);
      compare("start_delay_ms", e.start_delay_ms, a.start_delay_ms);
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  sspc_if #(.payload_t(drive_req_t)) req_ch (clk_i);
  sspc_if #(.payload_t(drive_res_t)) res_ch (clk_i);

  straight_speed_phase_pi_control DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (req_ch),
    .out_ch     (res_ch)
  );

  drive_scoreboard sb = new();
  int send_idle_pct, recv_stall_pct;
  int n_starts, n_samples;
  bit [31:0] cur_l, cur_r, cur_lt, cur_rt;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Hold ready at random and check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #20ms;
    $display("[straight_speed_phase_pi_control] ERROR");
    $finish;
  end

  task automatic send(drive_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.note_input(r);
    if (r.req_type == ReqStart) n_starts++; else n_samples++;
  endtask

  // Drop valid, let every result come back, then allow for latency
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Hold the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, bit [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgW-1:0];
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(bit [31:0] rl, bit [31:0] rr, bit [31:0] sl, bit [31:0] sr,
                           bit [31:0] w);
    drain();
    write_reg(RegLeftRpm, rl);
    write_reg(RegRightRpm, rr);
    write_reg(RegLeftSteps, sl);
    write_reg(RegRightSteps, sr);
    write_reg(RegWall, w);
    cfg_we_i <= 1'b0;
  endtask

  task automatic start_move(bit [31:0] l, bit [31:0] r, bit [31:0] lt, bit [31:0] rt);
    drive_req_t q;
    cur_l = l; cur_r = r; cur_lt = lt; cur_rt = rt;
    q = '0;
    q.req_type = ReqStart;
    q.left_count = l; q.right_count = r; q.left_stamp = lt; q.right_stamp = rt;
    q.center_read_a = 14'($urandom); q.center_read_b = 14'($urandom);
    send(q);
  endtask

  // Advance both wheels by a plausible step and send a sample
  task automatic step_move(int max_step, bit wall_hit);
    drive_req_t q;
    cur_l += $urandom_range(max_step);
    cur_r += $urandom_range(max_step);
    cur_lt += ($urandom_range(19) == 0) ? 0 : $urandom_range(2000000, 50000);
    cur_rt += $urandom_range(2000000, 50000);
    q.req_type = ReqSample;
    q.left_count = cur_l; q.right_count = cur_r;
    q.left_stamp = cur_lt; q.right_stamp = cur_rt;
    if (wall_hit) begin
      q.center_read_a = 14'($urandom_range(16383, sb.wall));
      q.center_read_b = 14'($urandom);
    end else begin
      q.center_read_a = 14'($urandom_range(sb.wall));
      q.center_read_b = 14'($urandom_range(sb.wall));
    end
    send(q);
  endtask

  task automatic noise_item();
    drive_req_t q;
    q.req_type = ReqSample;
    q.left_count = $urandom; q.right_count = $urandom;
    q.left_stamp = $urandom; q.right_stamp = $urandom;
    q.center_read_a = 14'($urandom); q.center_read_b = 14'($urandom);
    send(q);
  endtask

  initial begin
    int total, ph;
    drive_req_t q;
    sb.clear();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0; cfg_idx_i <= '0; cfg_data_i <= '0;
    req_ch.valid <= 1'b0; req_ch.data <= '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    n_starts = 0; n_samples = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: sample while idle, rejected start at reset config
    q = '1;
    send(q);
    start_move(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    configure(65535, 65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16383);
    start_move(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
    step_move(0, 0);
    step_move(20, 0);
    step_move(20, 0);
    start_move(0, 0, 0, 0);
    q = '0;
    q.req_type = ReqSample;
    q.left_count = 32'h8000_0000; q.right_count = 32'h7FFF_FFFF;
    q.left_stamp = 32'hFFFF_FFFF; q.right_stamp = 32'h0000_0001;
    q.center_read_a = 14'h3FFF; q.center_read_b = 14'h3FFF;
    send(q);
    configure(1000, 1200, 1, 2, 0);
    start_move(100, 100, 1000, 1000);
    step_move(3, 0);
    step_move(3, 0);
    step_move(3, 0);
    configure(2000, 2000, 300, 400, 500);
    start_move(5000, 6000, 1000, 1000);
    step_move(10, 0);
    step_move(10, 0);
    step_move(10, 1);
    start_move(0, 0, 0, 0);
    start_move(10, 10, 10, 10);
    configure(0, 500, 300, 300, 8900);
    start_move(0, 0, 0, 0);
    noise_item();

    // Random moves across idling phases and settings
    total = 0;
    ph = 0;
    while (total < 700) begin
      if (total >= ph * 100) begin
        case (ph % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
          default: begin send_idle_pct = 33; recv_stall_pct = 33; end
        endcase
        configure($urandom_range(3000, 1), $urandom_range(3000, 1),
                  (ph == 5) ? 32'h7FFF_FFFF : $urandom_range(1500, 1),
                  $urandom_range(1500, 1),
                  (ph == 6) ? 16383 : $urandom_range(16383, 2000));
        ph++;
      end
      start_move($urandom, $urandom, $urandom, $urandom);
      total++;
      repeat ($urandom_range(40, 5)) begin
        case ($urandom_range(19))
          0: noise_item();
          1: step_move(20, 1);
          default: step_move(($urandom_range(3) == 0) ? 60 : 20, 0);
        endcase
        total++;
      end
    end

    drain();
    $display("Covered %0d starts and %0d samples over %0d settings, %0d results checked.",
             n_starts, n_samples, ph + 4, sb.checked);
    if (sb.errors == 0) begin
      $display("[straight_speed_phase_pi_control] OK");
    end else begin
      $display("[straight_speed_phase_pi_control] ERROR");
    end
    $finish;
  end

endmodule
